// ----- hdl/elt_pkg.sv -----
package elt_pkg;

  localparam longint unsigned MAX_SOURCE_BYTES = 65535;
  localparam longint unsigned POS_LIMIT        = 131069;
  localparam logic [16:0]     POS_CAP          =
    17'(MAX_SOURCE_BYTES < POS_LIMIT ? MAX_SOURCE_BYTES : POS_LIMIT);
  localparam logic [15:0]     LEN_CAP          = 16'hFFFF;

  localparam int ELT_QUEUE_DEPTH = 4;
  localparam int MAX_RESULTS     = 3;

  localparam logic [7:0] CH_L          = 8'h6C;
  localparam logic [7:0] CH_E          = 8'h65;
  localparam logic [7:0] CH_T          = 8'h74;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_SEMI       = 8'h3B;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_DOT
  } lex_mode_t;

  typedef enum logic [4:0] {
    KIND_LET,
    KIND_IDENT,
    KIND_NUMBER,
    KIND_STRING,
    KIND_CONCAT,
    KIND_PLUS,
    KIND_MINUS,
    KIND_STAR,
    KIND_SLASH,
    KIND_LPAREN,
    KIND_RPAREN,
    KIND_EQUAL,
    KIND_COMMA,
    KIND_SEMI,
    KIND_EOF,
    KIND_BAD,
    KIND_UNTERM
  } token_kind_t;

  typedef struct packed {
    token_kind_t kind;
    logic [16:0] pos;
    logic [15:0] len;
    logic [7:0]  bad;
  } token_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    token_t [MAX_RESULTS-1:0]     tok;
  } bundle_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] prog);
    logic [7:0] ch;
    case (prog)
      2'd0:    ch = CH_L;
      2'd1:    ch = CH_E;
      default: ch = CH_T;
    endcase
    return ch;
  endfunction

  function automatic token_kind_t op_kind(input logic [7:0] c);
    token_kind_t k;
    case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_EQUAL:  k = KIND_EQUAL;
      CH_COMMA:  k = KIND_COMMA;
      CH_SEMI:   k = KIND_SEMI;
      default:   k = KIND_BAD;
    endcase
    return k;
  endfunction

  function automatic logic [16:0] pos_inc(input logic [16:0] p);
    return (p < POS_CAP) ? p + 17'd1 : p;
  endfunction

  function automatic logic [15:0] len_inc(input logic [15:0] l);
    return (l != LEN_CAP) ? l + 16'd1 : l;
  endfunction

  function automatic token_t mk_token(input token_kind_t kind, input logic [16:0] pos,
                                      input logic [15:0] len, input logic [7:0] bad);
    token_t t;
    t.kind = kind;
    t.pos  = pos;
    t.len  = len;
    t.bad  = bad;
    return t;
  endfunction

endpackage

// ----- hdl/elt_front.sv -----
module elt_front import elt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_end_i,
  output logic       ready_o,
  input  logic       full_i,
  output logic       push_o,
  output bundle_t    bundle_o
);

  lex_mode_t   mode_r, mode_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [1:0]  kprog_r, kprog_nxt;
  logic        kposs_r, kposs_nxt;

  logic        acc;
  logic [1:0]  cnt_v;
  logic        do_idle;
  token_kind_t word_kind;
  token_kind_t op_v;
  bundle_t     bundle_v;

  assign ready_o = !full_i;
  assign acc     = in_valid_i && ready_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      len_r   <= '0;
      kprog_r <= '0;
      kposs_r <= 1'b1;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      kprog_r <= kprog_nxt;
      kposs_r <= kposs_nxt;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    kprog_nxt = kprog_r;
    kposs_nxt = kposs_r;
    cnt_v     = 2'd0;
    do_idle   = 1'b0;
    bundle_v  = '0;
    op_v      = op_kind(in_byte_i);

    if (mode_r == MODE_NUMBER) begin
      word_kind = KIND_NUMBER;
    end else if (kposs_r && kprog_r == 2'd3 && len_r == 16'd3) begin
      word_kind = KIND_LET;
    end else begin
      word_kind = KIND_IDENT;
    end

    if (in_end_i) begin
      case (mode_r)
        MODE_IDENT, MODE_NUMBER: begin
          bundle_v.tok[cnt_v] = mk_token(word_kind, pos_nxt, len_r, 8'd0);
          cnt_v = cnt_v + 2'd1;
        end
        MODE_STRING: begin
          bundle_v.tok[cnt_v] = mk_token(KIND_UNTERM, pos_nxt, len_r, 8'd0);
          cnt_v = cnt_v + 2'd1;
          pos_nxt = pos_inc(pos_nxt);
          bundle_v.tok[cnt_v] = mk_token(KIND_STRING, pos_nxt, len_r, 8'd0);
          cnt_v = cnt_v + 2'd1;
        end
        MODE_DOT: begin
          bundle_v.tok[cnt_v] = mk_token(KIND_BAD, pos_nxt, 16'd0, CH_DOT);
          cnt_v = cnt_v + 2'd1;
          pos_nxt = pos_inc(pos_nxt);
        end
        default: begin
        end
      endcase
      bundle_v.tok[cnt_v] = mk_token(KIND_EOF, pos_nxt, 16'd0, 8'd0);
      cnt_v     = cnt_v + 2'd1;
      mode_nxt  = MODE_IDLE;
      pos_nxt   = '0;
      len_nxt   = '0;
      kprog_nxt = '0;
      kposs_nxt = 1'b1;
    end else begin
      case (mode_r)
        MODE_IDENT: begin
          if (is_letter(in_byte_i) || is_numeral(in_byte_i) || in_byte_i == CH_UNDERSCORE) begin
            if (kposs_r && kprog_r != 2'd3 && in_byte_i == kw_char(kprog_r)) begin
              kprog_nxt = kprog_r + 2'd1;
            end else begin
              kposs_nxt = 1'b0;
            end
            len_nxt = len_inc(len_r);
            pos_nxt = pos_inc(pos_r);
          end else begin
            bundle_v.tok[cnt_v] = mk_token(word_kind, pos_r, len_r, 8'd0);
            cnt_v    = cnt_v + 2'd1;
            mode_nxt = MODE_IDLE;
            do_idle  = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_numeral(in_byte_i)) begin
            len_nxt = len_inc(len_r);
            pos_nxt = pos_inc(pos_r);
          end else begin
            bundle_v.tok[cnt_v] = mk_token(word_kind, pos_r, len_r, 8'd0);
            cnt_v    = cnt_v + 2'd1;
            mode_nxt = MODE_IDLE;
            do_idle  = 1'b1;
          end
        end
        MODE_STRING: begin
          if (in_byte_i == CH_QUOTE) begin
            bundle_v.tok[cnt_v] = mk_token(KIND_STRING, pos_r + 17'd1, len_r, 8'd0);
            cnt_v    = cnt_v + 2'd1;
            mode_nxt = MODE_IDLE;
          end else begin
            len_nxt = len_inc(len_r);
          end
          pos_nxt = pos_inc(pos_r);
        end
        MODE_DOT: begin
          mode_nxt = MODE_IDLE;
          if (in_byte_i == CH_DOT) begin
            bundle_v.tok[cnt_v] = mk_token(KIND_CONCAT, pos_r + 17'd2, 16'd0, 8'd0);
            cnt_v   = cnt_v + 2'd1;
            pos_nxt = pos_inc(pos_inc(pos_r));
          end else begin
            bundle_v.tok[cnt_v] = mk_token(KIND_BAD, pos_r, 16'd0, CH_DOT);
            cnt_v   = cnt_v + 2'd1;
            pos_nxt = pos_inc(pos_r);
            do_idle = 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          do_idle  = 1'b1;
        end
      endcase

      if (do_idle) begin
        if (is_blank(in_byte_i)) begin
          pos_nxt = pos_inc(pos_nxt);
        end else if (is_letter(in_byte_i) || in_byte_i == CH_UNDERSCORE) begin
          mode_nxt  = MODE_IDENT;
          len_nxt   = 16'd1;
          kprog_nxt = (in_byte_i == CH_L) ? 2'd1 : 2'd0;
          kposs_nxt = (in_byte_i == CH_L);
          pos_nxt   = pos_inc(pos_nxt);
        end else if (is_numeral(in_byte_i)) begin
          mode_nxt = MODE_NUMBER;
          len_nxt  = 16'd1;
          pos_nxt  = pos_inc(pos_nxt);
        end else if (in_byte_i == CH_QUOTE) begin
          mode_nxt = MODE_STRING;
          len_nxt  = 16'd0;
          pos_nxt  = pos_inc(pos_nxt);
        end else if (in_byte_i == CH_DOT) begin
          mode_nxt = MODE_DOT;
        end else begin
          bundle_v.tok[cnt_v] = mk_token(op_v, pos_nxt, 16'd0,
                                         (op_v == KIND_BAD) ? in_byte_i : 8'd0);
          cnt_v   = cnt_v + 2'd1;
          pos_nxt = pos_inc(pos_nxt);
        end
      end
    end

    bundle_v.cnt = cnt_v;
  end

  assign bundle_o = bundle_v;
  assign push_o   = acc && (cnt_v != 2'd0);

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_end_i) |=> (mode_r == MODE_IDLE && pos_r == '0 && len_r == '0 && kposs_r))
    else $error("Lexer state not cleared after the end beat.");

  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_end_i) |-> push_o)
    else $error("End beat produced no eof token.");

endmodule

// ----- hdl/elt_queue.sv -----
module elt_queue import elt_pkg::*; #(
  parameter int DEPTH = ELT_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_i,
  input  bundle_t din_i,
  output logic    full_o,
  input  logic    pop_i,
  output bundle_t dout_o,
  output logic    valid_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_r == CW'(DEPTH));
  assign valid_o = (count_r != '0);
  assign dout_o  = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("Token bundle pushed into a full queue.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Queue fill count exceeds its depth.");

endmodule

// ----- hdl/elt_back.sv -----
module elt_back import elt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid_i,
  input  bundle_t q_data_i,
  output logic    q_pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output token_t  out_token_o,
  output logic    out_last_o
);

  bundle_t    cur_r, cur_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic       last;
  logic       done;

  assign last        = (idx_r == cur_r.cnt - 2'd1);
  assign done        = vld_r && out_ready_i && last;
  assign q_pop_o     = q_valid_i && (!vld_r || done);
  assign out_valid_o = vld_r;
  assign out_token_o = cur_r.tok[idx_r];
  assign out_last_o  = last;

  always_comb begin
    cur_nxt = cur_r;
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (q_pop_o) begin
      cur_nxt = q_data_i;
      idx_nxt = 2'd0;
      vld_nxt = 1'b1;
    end else if (done) begin
      vld_nxt = 1'b0;
    end else if (vld_r && out_ready_i) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (cur_r.cnt != 2'd0))
    else $error("Back end holds an empty token bundle.");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (idx_r < cur_r.cnt))
    else $error("Token index ran past the bundle count.");

endmodule

// ----- hdl/expression_language_tokenizer_top.sv -----
// Streaming tokenizer for a small expression language. Each input beat carries one source
// byte, or with in_tlast high an end marker that flushes the open token, emits eof and
// returns the lexer to its reset state. The lexer takes one beat per cycle while in_tready
// is high and turns each into zero to three tokens; out_tlast marks the last token that a
// beat caused. Tokens leave at one per cycle while out_tready is high. A queue of
// QUEUE_DEPTH token bundles between the lexer and the output stage absorbs the bursts of
// tokens; in_tready falls only while that queue is full. The first token of a beat is
// written into the queue and then registered in the output stage before it is presented.
module expression_language_tokenizer_top import elt_pkg::*; #(
  parameter int QUEUE_DEPTH = ELT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // source_byte
  input  logic        in_tlast,   // end_marker
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // token_position, value_length, bad_byte, zero fill
  output logic [4:0]  out_tuser,  // token_kind
  output logic        out_tlast   // last_of_item
);

  logic    q_full;
  logic    q_push;
  bundle_t q_din;
  logic    q_pop;
  bundle_t q_dout;
  logic    q_valid;
  token_t  tok;

  elt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_byte_i  (in_tdata),
    .in_end_i   (in_tlast),
    .ready_o    (in_tready),
    .full_i     (q_full),
    .push_o     (q_push),
    .bundle_o   (q_din)
  );

  elt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .din_i   (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (q_dout),
    .valid_o (q_valid)
  );

  elt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_data_i    (q_dout),
    .q_pop_o     (q_pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_token_o (tok),
    .out_last_o  (out_tlast)
  );

  assign out_tdata = {7'd0, tok.bad, tok.len, tok.pos};
  assign out_tuser = tok.kind;

endmodule
